### sv/alt_pkg.sv
// Package for the address lease table: codes, register map and shared structs.
`timescale 1ns / 1ps

package alt_pkg;

    // Table size default
    localparam int LEASE_COUNT_DEF = 8;

    // Configuration register reset values and fixed constants
    localparam logic [21:0] LEASE_SECONDS_RST = 22'd86400;
    localparam logic [15:0] OFFER_HOLD_RST    = 16'd10000;
    localparam logic [31:0] SERVER_NAME_RST   = 32'd0;
    localparam logic [31:0] MS_PER_SEC        = 32'd1000;

    // APB address width: three registers at 4-byte spacing
    localparam int PADDR_W = 4;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_LEASE_SECONDS = 2'd0,
        REG_OFFER_HOLD    = 2'd1,
        REG_SERVER_NAME   = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    // Input operations
    typedef enum logic [1:0] {
        OP_DISCOVER = 2'd0,
        OP_REQUEST  = 2'd1,
        OP_OTHER    = 2'd2,
        OP_LOOKUP   = 2'd3
    } op_t;

    // Response codes
    typedef enum logic [2:0] {
        RSP_OFFER     = 3'd0,
        RSP_ACK       = 3'd1,
        RSP_NAK       = 3'd2,
        RSP_FOUND     = 3'd3,
        RSP_NOT_FOUND = 3'd4
    } rsp_code_t;

    // Entry states
    typedef enum logic [1:0] {
        ST_AVAILABLE = 2'd0,
        ST_OFFERED   = 2'd1,
        ST_ACKED     = 2'd2
    } entry_state_t;

    // Sweep modes carried by the search token
    typedef enum logic [1:0] {
        MODE_OWNER  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_LOOKUP = 2'd2
    } sweep_mode_t;

    // Configuration register contents
    typedef struct packed {
        logic [21:0] lease_seconds;
        logic [15:0] offer_hold_ms;
        logic [31:0] server_name_hash;
    } cfg_t;

    // Search token control bits handed from cell to cell
    typedef struct packed {
        logic        valid;
        sweep_mode_t mode;
        logic        found_a;
        logic        found_b;
    } token_t;

    // Values broadcast to all cells during a sweep
    typedef struct packed {
        logic [31:0]        key;
        logic [31:0]        label;
        logic signed [31:0] now;
    } bcast_t;

    // Entry write broadcast; the target number travels beside it
    typedef struct packed {
        logic         en;
        logic [31:0]  owner;
        logic [31:0]  expiry;
        entry_state_t state;
        logic [31:0]  host;
    } entry_wr_t;

endpackage

### sv/alt_if.sv
// Valid/ready channel interfaces for lease requests and responses.
`timescale 1ns / 1ps

interface alt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [31:0]        mac_hash;
    logic [31:0]        host_hash;
    logic [31:0]        label_hash;
    logic signed [31:0] now_ms;

    modport source (
        output valid, op, mac_hash, host_hash, label_hash, now_ms,
        input  ready
    );
    modport sink (
        input  valid, op, mac_hash, host_hash, label_hash, now_ms,
        output ready
    );
endinterface

interface alt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] response;
    logic [3:0] lease_number;

    modport source (
        output valid, response, lease_number,
        input  ready
    );
    modport sink (
        input  valid, response, lease_number,
        output ready
    );
endinterface

### sv/alt_cfg.sv
// APB configuration registers of the address lease table.
`timescale 1ns / 1ps

module alt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [alt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output alt_pkg::cfg_t               cfg
);

    alt_pkg::cfg_t      cfg_reg;
    alt_pkg::reg_idx_t  reg_idx;
    logic               wr_strobe;

    assign pready    = 1'b1;
    assign reg_idx   = alt_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_strobe = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lease_seconds    <= alt_pkg::LEASE_SECONDS_RST;
            cfg_reg.offer_hold_ms    <= alt_pkg::OFFER_HOLD_RST;
            cfg_reg.server_name_hash <= alt_pkg::SERVER_NAME_RST;
        end
        else if (wr_strobe)
        begin
            unique case (reg_idx)
                alt_pkg::REG_LEASE_SECONDS: cfg_reg.lease_seconds    <= pwdata[21:0];
                alt_pkg::REG_OFFER_HOLD:    cfg_reg.offer_hold_ms    <= pwdata[15:0];
                alt_pkg::REG_SERVER_NAME:   cfg_reg.server_name_hash <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux, zero-extended
    always_comb
    begin
        unique case (reg_idx)
            alt_pkg::REG_LEASE_SECONDS: prdata = {10'd0, cfg_reg.lease_seconds};
            alt_pkg::REG_OFFER_HOLD:    prdata = {16'd0, cfg_reg.offer_hold_ms};
            alt_pkg::REG_SERVER_NAME:   prdata = cfg_reg.server_name_hash;
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

### sv/alt_cell.sv
// One lease entry: holds its fields, matches the passing token and forwards it.
`timescale 1ns / 1ps

module alt_cell #(
    parameter int IW  = 4,
    parameter int NUM = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  alt_pkg::bcast_t    bcast,
    input  alt_pkg::entry_wr_t wr,
    input  logic [IW-1:0]      wr_idx,
    input  alt_pkg::token_t    tok_in,
    input  logic [IW-1:0]      idx_a_in,
    input  logic [IW-1:0]      idx_b_in,
    output alt_pkg::token_t    tok_out,
    output logic [IW-1:0]      idx_a_out,
    output logic [IW-1:0]      idx_b_out
);

    localparam logic [IW-1:0] MY_NUM = IW'(NUM);

    logic [31:0]           owner_reg;
    logic [31:0]           expiry_reg;
    alt_pkg::entry_state_t state_reg;
    logic [31:0]           host_reg;

    alt_pkg::token_t tok_reg;
    logic [IW-1:0]   idx_a_reg;
    logic [IW-1:0]   idx_b_reg;

    logic expired;
    logic acked;
    logic hit_a;
    logic hit_b;
    logic do_free;
    logic do_write;

    assign expired  = $signed(expiry_reg) < bcast.now;
    assign acked    = (state_reg == alt_pkg::ST_ACKED);
    assign do_free  = tok_in.valid && (tok_in.mode == alt_pkg::MODE_FREE) && expired;
    assign do_write = wr.en && (wr_idx == MY_NUM);

    // Local match for the current sweep
    always_comb
    begin
        hit_a = 1'b0;
        hit_b = 1'b0;
        unique case (tok_in.mode)
            alt_pkg::MODE_OWNER:  hit_a = (owner_reg == bcast.key);
            // a freed entry has owner zero
            alt_pkg::MODE_FREE:   hit_a = expired || (owner_reg == 32'd0);
            alt_pkg::MODE_LOOKUP:
            begin
                hit_a = acked && (host_reg == bcast.key);
                hit_b = acked && (host_reg == bcast.label);
            end
            default: ;
        endcase
    end

    // Entry storage: result write, or free when expired during a free sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg  <= 32'd0;
            expiry_reg <= 32'd0;
            state_reg  <= alt_pkg::ST_AVAILABLE;
            host_reg   <= 32'd0;
        end
        else if (do_write)
        begin
            owner_reg  <= wr.owner;
            expiry_reg <= wr.expiry;
            state_reg  <= wr.state;
            host_reg   <= wr.host;
        end
        else if (do_free)
        begin
            owner_reg  <= 32'd0;
            expiry_reg <= 32'd0;
            state_reg  <= alt_pkg::ST_AVAILABLE;
            host_reg   <= 32'd0;
        end
    end

    // Token stage toward the next cell; first hit wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
        end
        else
        begin
            tok_reg.valid   <= tok_in.valid;
            tok_reg.mode    <= tok_in.mode;
            tok_reg.found_a <= tok_in.found_a || (tok_in.valid && hit_a);
            tok_reg.found_b <= tok_in.found_b || (tok_in.valid && hit_b);
            idx_a_reg       <= (!tok_in.found_a && hit_a) ? MY_NUM : idx_a_in;
            idx_b_reg       <= (!tok_in.found_b && hit_b) ? MY_NUM : idx_b_in;
        end
    end

    assign tok_out   = tok_reg;
    assign idx_a_out = idx_a_reg;
    assign idx_b_out = idx_b_reg;

endmodule

### sv/address_lease_table_unit.sv
// Address lease table top level: request control, cell chain and config port.
// Sequence: a lookup or an owner hit takes one token sweep down the cell chain;
// an owner miss adds a free sweep before the result.
// Throughput: one item at a time, set by the token walking the cell chain one cell
// per cycle; the result register lets the next item start while the last result
// waits to be taken.
// Reset: all entries cleared to free at once, registers to their defaults.
`timescale 1ns / 1ps

module address_lease_table_unit #(
    parameter int LEASE_COUNT = alt_pkg::LEASE_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    alt_req_if.sink                     req,
    alt_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [alt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IW = $clog2(LEASE_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP_OWNER,
        S_SWEEP_FREE,
        S_DONE
    } state_t;

    state_t              state_reg;
    alt_pkg::op_t        op_reg;
    logic [31:0]         mac_reg;
    logic [31:0]         host_reg;
    alt_pkg::bcast_t     bcast_reg;
    logic                inject_reg;
    alt_pkg::sweep_mode_t inj_mode_reg;
    alt_pkg::entry_wr_t  wr_reg;
    logic [IW-1:0]       wr_idx_reg;
    alt_pkg::rsp_code_t  res_code_reg;
    logic [IW-1:0]       res_lease_reg;
    logic                rsp_valid_reg;
    alt_pkg::rsp_code_t  rsp_code_reg;
    logic [3:0]          rsp_lease_reg;

    alt_pkg::cfg_t       cfg;
    alt_pkg::token_t     tok   [LEASE_COUNT+1];
    logic [IW-1:0]       idx_a [LEASE_COUNT+1];
    logic [IW-1:0]       idx_b [LEASE_COUNT+1];
    logic [LEASE_COUNT-1:0] tok_busy;

    alt_pkg::token_t     tok_end;
    logic [IW-1:0]       end_a;
    logic [IW-1:0]       end_b;
    logic [31:0]         offer_expiry;
    logic [31:0]         lease_expiry;
    logic                req_xfer;

    // Configuration registers
    alt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Token entry into the first cell
    assign tok[0].valid   = inject_reg;
    assign tok[0].mode    = inj_mode_reg;
    assign tok[0].found_a = 1'b0;
    assign tok[0].found_b = 1'b0;
    assign idx_a[0]       = '0;
    assign idx_b[0]       = '0;

    // Chain of entry cells
    for (genvar i = 0; i < LEASE_COUNT; i++)
    begin : g_cell
        alt_cell #(
            .IW  (IW),
            .NUM (i + 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bcast     (bcast_reg),
            .wr        (wr_reg),
            .wr_idx    (wr_idx_reg),
            .tok_in    (tok[i]),
            .idx_a_in  (idx_a[i]),
            .idx_b_in  (idx_b[i]),
            .tok_out   (tok[i+1]),
            .idx_a_out (idx_a[i+1]),
            .idx_b_out (idx_b[i+1])
        );
        assign tok_busy[i] = tok[i].valid;
    end

    assign tok_end = tok[LEASE_COUNT];
    assign end_a   = idx_a[LEASE_COUNT];
    assign end_b   = idx_b[LEASE_COUNT];

    // New expiry times, modulo 2^32
    assign offer_expiry = 32'(bcast_reg.now) + {16'd0, cfg.offer_hold_ms};
    assign lease_expiry = 32'(bcast_reg.now) + 32'({10'd0, cfg.lease_seconds} * alt_pkg::MS_PER_SEC);

    assign req_xfer  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.response     = rsp_code_reg;
    assign rsp.lease_number = rsp_lease_reg;

    // Request sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= alt_pkg::OP_DISCOVER;
            mac_reg       <= 32'd0;
            host_reg      <= 32'd0;
            bcast_reg     <= '0;
            inject_reg    <= 1'b0;
            inj_mode_reg  <= alt_pkg::MODE_OWNER;
            wr_reg        <= '0;
            wr_idx_reg    <= '0;
            res_code_reg  <= alt_pkg::RSP_NAK;
            res_lease_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_code_reg  <= alt_pkg::RSP_NAK;
            rsp_lease_reg <= 4'd0;
        end
        else
        begin
            inject_reg <= 1'b0;
            wr_reg.en  <= 1'b0;
            if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer)
                    begin
                        op_reg          <= alt_pkg::op_t'(req.op);
                        mac_reg         <= req.mac_hash;
                        host_reg        <= req.host_hash;
                        bcast_reg.label <= req.label_hash;
                        bcast_reg.now   <= req.now_ms;
                        inject_reg      <= 1'b1;
                        if (alt_pkg::op_t'(req.op) == alt_pkg::OP_LOOKUP)
                        begin
                            bcast_reg.key <= req.host_hash;
                            inj_mode_reg  <= alt_pkg::MODE_LOOKUP;
                        end
                        else
                        begin
                            bcast_reg.key <= req.mac_hash;
                            inj_mode_reg  <= alt_pkg::MODE_OWNER;
                        end
                        state_reg <= S_SWEEP_OWNER;
                    end
                end

                S_SWEEP_OWNER:
                begin
                    if (tok_end.valid)
                    begin
                        if (op_reg == alt_pkg::OP_LOOKUP)
                        begin
                            // full name first, then label, then the server itself
                            res_lease_reg <= tok_end.found_a ? end_a :
                                             (tok_end.found_b ? end_b : '0);
                            res_code_reg  <= (tok_end.found_a || tok_end.found_b ||
                                              host_reg == cfg.server_name_hash) ?
                                             alt_pkg::RSP_FOUND : alt_pkg::RSP_NOT_FOUND;
                            state_reg     <= S_DONE;
                        end
                        else if (tok_end.found_a)
                        begin
                            res_lease_reg <= end_a;
                            wr_idx_reg    <= end_a;
                            wr_reg.owner  <= mac_reg;
                            priority if (op_reg == alt_pkg::OP_DISCOVER)
                            begin
                                wr_reg.en     <= 1'b1;
                                wr_reg.expiry <= offer_expiry;
                                wr_reg.state  <= alt_pkg::ST_OFFERED;
                                wr_reg.host   <= 32'd0;
                                res_code_reg  <= alt_pkg::RSP_OFFER;
                            end
                            else if (op_reg == alt_pkg::OP_REQUEST)
                            begin
                                wr_reg.en     <= 1'b1;
                                wr_reg.expiry <= lease_expiry;
                                wr_reg.state  <= alt_pkg::ST_ACKED;
                                wr_reg.host   <= host_reg;
                                res_code_reg  <= alt_pkg::RSP_ACK;
                            end
                            else
                            begin
                                res_code_reg <= alt_pkg::RSP_NAK;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // owner miss: free expired entries, look for a free one
                            inject_reg   <= 1'b1;
                            inj_mode_reg <= alt_pkg::MODE_FREE;
                            state_reg    <= S_SWEEP_FREE;
                        end
                    end
                end

                S_SWEEP_FREE:
                begin
                    if (tok_end.valid)
                    begin
                        if (op_reg == alt_pkg::OP_DISCOVER && tok_end.found_a)
                        begin
                            wr_reg.en     <= 1'b1;
                            wr_idx_reg    <= end_a;
                            wr_reg.owner  <= mac_reg;
                            wr_reg.expiry <= offer_expiry;
                            wr_reg.state  <= alt_pkg::ST_OFFERED;
                            wr_reg.host   <= 32'd0;
                            res_code_reg  <= alt_pkg::RSP_OFFER;
                            res_lease_reg <= end_a;
                        end
                        else
                        begin
                            res_code_reg  <= alt_pkg::RSP_NAK;
                            res_lease_reg <= '0;
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_code_reg  <= res_code_reg;
                        rsp_lease_reg <= 4'(res_lease_reg);
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An entry write never overlaps a token in the chain
    a_wr_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg.en |-> (tok_busy == '0 && !tok_end.valid))
        else $error("entry write during a sweep");

    // Idle means no sweep in flight
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (tok_busy == '0 && !tok_end.valid))
        else $error("token in chain while idle");

    // An accepted item starts a sweep in the next cycle
    a_start_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (inject_reg && state_reg == S_SWEEP_OWNER))
        else $error("accepted item did not start a sweep");

    // A result is loaded only when the sequencer leaves the done state
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE && state_reg == S_IDLE))
        else $error("result loaded outside the done state");

endmodule
